/* src/windowed_rms_level_detector_unit_assert.svh */
// assertion macros for the windowed rms level detector checker
`ifndef WINDOWED_RMS_LEVEL_DETECTOR_UNIT_ASSERT_SVH
`define WINDOWED_RMS_LEVEL_DETECTOR_UNIT_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define WRMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define WRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wrms_pkg.sv */
// shared widths, reset values, register indexes and types of the rms level detector
`default_nettype none

package wrms_pkg;

    localparam int W_SAMPLE   = 32;
    localparam int W_LEN      = 14;
    localparam int W_LEVEL    = 32;
    localparam int W_SUM      = 64;
    localparam int W_REM      = 33;
    localparam int W_SUB      = 35;
    localparam int W_ITER     = 6;
    localparam int W_ADDR     = 3;
    localparam int W_DATA     = 32;
    localparam int ADDR_SEL   = 2;
    localparam int MAX_WINDOW = 8192;

    localparam logic [W_LEN-1:0]   MAX_LEN         = W_LEN'(MAX_WINDOW);
    localparam logic [W_LEN-1:0]   LEN_RESET       = 14'd8150;
    localparam logic [W_LEVEL-1:0] THRESHOLD_RESET = 32'd31000000;

    // register index, taken from the word address
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_RMS_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [W_LEN-1:0]   window_length;
        logic [W_LEVEL-1:0] rms_threshold;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [W_LEVEL-1:0] level;
    } t_res;

endpackage

`default_nettype wire

/* src/wrms_regs.sv */
// configuration register file behind the apb port
`default_nettype none

module wrms_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wrms_pkg::W_ADDR-1:0]    paddr,
    input  logic [wrms_pkg::W_DATA-1:0]    pwdata,
    output logic [wrms_pkg::W_DATA-1:0]    prdata,
    output logic                           pready,
    output wrms_pkg::t_cfg                 o_cfg
);
    import wrms_pkg::*;

    logic [W_LEN-1:0]   r_window_length;
    logic [W_LEN-1:0]   n_window_length;
    logic [W_LEVEL-1:0] r_rms_threshold;
    logic [W_LEVEL-1:0] n_rms_threshold;
    logic               w_write;

    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_window_length = r_window_length;
        n_rms_threshold = r_rms_threshold;
        if (w_write) begin
            case (paddr[ADDR_SEL])
                REG_WINDOW_LENGTH: n_window_length = pwdata[W_LEN-1:0];
                REG_RMS_THRESHOLD: n_rms_threshold = pwdata[W_LEVEL-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= LEN_RESET;
            r_rms_threshold <= THRESHOLD_RESET;
        end else begin
            r_window_length <= n_window_length;
            r_rms_threshold <= n_rms_threshold;
        end
    end

    always_comb begin
        case (paddr[ADDR_SEL])
            REG_WINDOW_LENGTH: prdata = W_DATA'(r_window_length);
            REG_RMS_THRESHOLD: prdata = W_DATA'(r_rms_threshold);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.window_length = r_window_length;
    assign o_cfg.rms_threshold = r_rms_threshold;

endmodule

`default_nettype wire

/* src/wrms_sub.sv */
// shared subtract and compare unit for division and square root steps
`default_nettype none

module wrms_sub (
    input  logic [wrms_pkg::W_SUB-1:0] i_a,
    input  logic [wrms_pkg::W_SUB-1:0] i_b,
    output logic [wrms_pkg::W_SUB-1:0] o_diff,
    output logic                       o_ge
);
    import wrms_pkg::*;

    logic [W_SUB:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[W_SUB-1:0];
    // no borrow out means a >= b
    assign o_ge   = ~w_full[W_SUB];

endmodule

`default_nettype wire

/* src/wrms_core.sv */
// sequencer and datapath: square, saturating accumulate, divide, square root
`default_nettype none

module wrms_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [wrms_pkg::W_SAMPLE-1:0] i_sample,
    output logic                               o_stall,
    input  logic [wrms_pkg::W_LEN-1:0]         i_cfg_len,
    output wrms_pkg::t_res                     o_res,
    input  logic                               i_res_take
);
    import wrms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_DIVIDE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic signed [W_SAMPLE-1:0]  r_sample, n_sample;
    logic [W_SUM-1:0]            r_sq, n_sq;
    logic [W_SUM-1:0]            r_sum, n_sum;
    logic [W_LEN-1:0]            r_count, n_count;
    logic [W_LEN-1:0]            r_div, n_div;
    logic [W_SUM-1:0]            r_shift, n_shift;
    logic [W_REM-1:0]            r_rem, n_rem;
    logic [W_LEVEL-1:0]          r_root, n_root;
    logic [W_ITER-1:0]           r_iter, n_iter;

    logic [W_SAMPLE-1:0]         w_mag;
    logic [W_SUM-1:0]            w_sq;
    logic [W_SUM:0]              w_add;
    logic [W_SUM-1:0]            w_sum_sat;
    logic [W_LEN-1:0]            w_n;
    logic [W_LEN-1:0]            w_eff;
    logic                        w_close;
    logic [W_SUB-1:0]            w_a, w_b, w_diff;
    logic                        w_ge;
    logic [W_REM-1:0]            w_rem_next;

    // magnitude; the most negative sample gives 2^31 in unsigned form
    assign w_mag = r_sample[W_SAMPLE-1] ? (~r_sample + 1'b1) : r_sample;
    assign w_sq  = w_mag * w_mag;

    assign w_add     = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_sum_sat = w_add[W_SUM] ? '1 : w_add[W_SUM-1:0];

    assign w_n = r_count + 1'b1;

    always_comb begin
        if (i_cfg_len == '0) begin
            w_eff = W_LEN'(1);
        end else if (i_cfg_len > MAX_LEN) begin
            w_eff = MAX_LEN;
        end else begin
            w_eff = i_cfg_len;
        end
    end

    assign w_close = (w_n >= w_eff);

    // operand select for the shared unit
    always_comb begin
        if (r_state == S_DIVIDE) begin
            w_a = W_SUB'({r_rem[W_LEN-1:0], r_shift[W_SUM-1]});
            w_b = W_SUB'(r_div);
        end else begin
            w_a = {r_rem, r_shift[W_SUM-1 -: 2]};
            w_b = W_SUB'({r_root, 2'b01});
        end
    end

    wrms_sub u_sub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_rem_next = w_ge ? w_diff[W_REM-1:0] : w_a[W_REM-1:0];

    always_comb begin
        n_state  = r_state;
        n_sample = r_sample;
        n_sq     = r_sq;
        n_sum    = r_sum;
        n_count  = r_count;
        n_div    = r_div;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_root   = r_root;
        n_iter   = r_iter;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    n_state  = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_sq    = w_sq;
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                if (w_close) begin
                    n_shift = w_sum_sat;
                    n_div   = w_n;
                    n_rem   = '0;
                    n_iter  = W_ITER'(W_SUM - 1);
                    n_sum   = '0;
                    n_count = '0;
                    n_state = S_DIVIDE;
                end else begin
                    n_sum   = w_sum_sat;
                    n_count = w_n;
                    n_state = S_IDLE;
                end
            end
            S_DIVIDE: begin
                // one quotient bit a step, quotient shifts in behind the dividend
                n_rem   = w_rem_next;
                n_shift = {r_shift[W_SUM-2:0], w_ge};
                if (r_iter == '0) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = W_ITER'(W_LEVEL - 1);
                    n_state = S_ROOT;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end
            S_ROOT: begin
                // one root bit a step from two bits of the mean
                n_rem   = w_rem_next;
                n_root  = {r_root[W_LEVEL-2:0], w_ge};
                n_shift = {r_shift[W_SUM-3:0], 2'b00};
                if (r_iter == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
        r_sample <= n_sample;
        r_sq     <= n_sq;
        r_div    <= n_div;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_iter   <= n_iter;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.level = r_root;

endmodule

`default_nettype wire

/* src/windowed_rms_level_detector_unit.sv */
// top level of the windowed rms level detector
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_sample (32 bit signed)
//   output    out        o_valid / i_stall   o_rms_level (32 bit), o_loud
//   config    in         apb psel / penable  paddr 0 window_length, 4 rms_threshold
//
// an item that does not close the window keeps o_stall high through the square and accumulate steps after it is taken
// an item that closes the window passes through square and accumulate, then 64 steps of
//   the shared 35 bit subtractor for the quotient, 32 more for the root, then the hand over
// i_rst_n is synchronous: sum, sample count, sequencer and output valid clear,
//   registers return to window 8150 and threshold 31000000
// a waiting result sits in the output register while the next item is taken;
//   only a second finished result waits for it to be taken
`default_nettype none

module windowed_rms_level_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [wrms_pkg::W_SAMPLE-1:0] i_sample,
    // result item channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [wrms_pkg::W_LEVEL-1:0]         o_rms_level,
    output logic                                 o_loud,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wrms_pkg::W_ADDR-1:0]          paddr,
    input  logic [wrms_pkg::W_DATA-1:0]          pwdata,
    output logic [wrms_pkg::W_DATA-1:0]          prdata,
    output logic                                 pready
);
    import wrms_pkg::*;

    t_cfg               w_cfg;
    t_res               w_res;
    logic               w_take;

    logic               r_valid;
    logic [W_LEVEL-1:0] r_level;
    logic               r_loud;

    // register file
    wrms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer with the shared subtractor
    wrms_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .o_stall    (o_stall),
        .i_cfg_len  (w_cfg.window_length),
        .o_res      (w_res),
        .i_res_take (w_take)
    );

    // finished result moves in when the output register is empty or being emptied
    assign w_take = w_res.valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_level <= w_res.level;
            // threshold compare: loud when the level is above the rms threshold
            r_loud  <= (w_res.level > w_cfg.rms_threshold);
        end
    end

    assign o_valid     = r_valid;
    assign o_rms_level = r_level;
    assign o_loud      = r_loud;

endmodule

`default_nettype wire

/* src/wrms_checker.sv */
// port level checks for the windowed rms level detector, bound to the top level
`default_nettype none

`include "windowed_rms_level_detector_unit_assert.svh"

module wrms_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic [wrms_pkg::W_LEVEL-1:0]         o_rms_level,
    input  logic                                 o_loud
);

    // a taken item always keeps the sequencer busy in the cycle after it is taken
    `WRMS_ASSERT_NEXT(a_busy_after_item, i_valid && !o_stall, o_stall, "item taken but block still ready")

    // a held result keeps its value
    `WRMS_ASSERT_NEXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_rms_level) && $stable(o_loud), "stalled result changed")

    // a fresh result only comes from a busy sequencer
    `WRMS_ASSERT_SAME(a_result_from_busy, $rose(o_valid), $past(o_stall), "result appeared from idle sequencer")

    // with the sequencer idle a taken result is not replaced
    `WRMS_ASSERT_NEXT(a_no_phantom, o_valid && !i_stall && !o_stall, !o_valid, "result appeared without work")

endmodule

bind windowed_rms_level_detector_unit wrms_checker u_wrms_checker (.*);

`default_nettype wire
